@@ rtl/core/mp2_pkg.sv @@
`timescale 1ns / 1ps

package mp2_pkg;

   // Defaults for the top-level parameters
   localparam int PIXEL_WIDTH_DEFAULT  = 16;
   localparam int MAX_IN_SIZE_DEFAULT  = 256;
   localparam int MAX_CHANNELS_DEFAULT = 1024;

   // Control register widths
   localparam int IN_SIZE_WIDTH       = 9;
   localparam int POOLED_DIM_WIDTH    = 8;
   localparam int CHANNEL_COUNT_WIDTH = 11;
   localparam int CSR_DATA_WIDTH      = 11;
   localparam int CSR_INDEX_WIDTH     = 2;

   // Control register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IN_SIZE       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POOLED_DIM    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Control register reset values
   localparam logic [IN_SIZE_WIDTH-1:0]       IN_SIZE_RESET       = 9'd2;
   localparam logic [POOLED_DIM_WIDTH-1:0]    POOLED_DIM_RESET    = 8'd1;
   localparam logic [CHANNEL_COUNT_WIDTH-1:0] CHANNEL_COUNT_RESET = 11'd1;

   // End-of-row / map / layer markers carried with a result
   typedef struct packed {
      logic last_in_row;
      logic last_in_map;
      logic last_in_layer;
   } flags_type;

   // Per-pixel decode handed from the position counters to the datapath
   typedef struct packed {
      logic      keep_left;   // even column inside the pooled square
      logic      store_pair;  // odd column of an even row: write pair max
      logic      emit;        // odd column of an odd row: window complete
      flags_type flags;
   } pool_ctrl_type;

endpackage

@@ rtl/core/mp2_window_path.sv @@
`timescale 1ns / 1ps

module mp2_window_path #(
   parameter int PIXEL_WIDTH = mp2_pkg::PIXEL_WIDTH_DEFAULT,
   parameter int LINE_DEPTH  = mp2_pkg::MAX_IN_SIZE_DEFAULT / 2,
   parameter int LW          = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  mp2_pkg::pool_ctrl_type        ctrl,
   input  logic [LW-1:0]                 slot,
   input  logic signed [PIXEL_WIDTH-1:0] pixel,
   input  logic                          s1_advance,
   output logic signed [PIXEL_WIDTH-1:0] pooled_value,
   output mp2_pkg::flags_type            flags
);

   logic signed [PIXEL_WIDTH-1:0] line_mem [LINE_DEPTH];
   logic signed [PIXEL_WIDTH-1:0] hold_ff;
   logic signed [PIXEL_WIDTH-1:0] pair;
   logic signed [PIXEL_WIDTH-1:0] above_ff;
   logic signed [PIXEL_WIDTH-1:0] pair_ff;
   mp2_pkg::flags_type            s1_flags_ff;
   logic signed [PIXEL_WIDTH-1:0] pooled_ff;
   mp2_pkg::flags_type            out_flags_ff;

   // Left pixel of the current horizontal pair
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else if (accept && ctrl.keep_left) begin
         hold_ff <= pixel;
      end
   end

   assign pair = (pixel > hold_ff) ? pixel : hold_ff;

   // Line store: even rows write pair maxima, odd rows read them back
   always_ff @(posedge clock) begin
      if (accept && ctrl.store_pair) begin
         line_mem[slot] <= pair;
      end
      if (accept && ctrl.emit) begin
         above_ff <= line_mem[slot];
      end
   end

   // Stage 1: pair of the odd row plus its markers
   always_ff @(posedge clock) begin
      if (accept && ctrl.emit) begin
         pair_ff     <= pair;
         s1_flags_ff <= ctrl.flags;
      end
   end

   // Output register: final window maximum
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         pooled_ff    <= (above_ff > pair_ff) ? above_ff : pair_ff;
         out_flags_ff <= s1_flags_ff;
      end
   end

   assign pooled_value = pooled_ff;
   assign flags        = out_flags_ff;

endmodule

@@ rtl/core/max_pool_2x2_stream.sv @@
`timescale 1ns / 1ps

// 2x2 stride-2 max pooling over a streamed multi-channel feature map. Pixels
// arrive in raster order, channel after channel; one pixel is taken every
// clock cycle when the result side keeps up. The window maximum of the pixel
// that completes the window passes through stage 1 (the line store read) and
// the output register before it appears on the rsp channel. Pixels outside
// the top-left 2*pooled_dim square are consumed and dropped. Pair maxima of
// even rows sit in a single-port line store of MAX_IN_SIZE/2 words; it needs
// no initialization. Control registers take effect immediately and should be
// written only while the block is idle.
module max_pool_2x2_stream #(
   parameter int PIXEL_WIDTH  = mp2_pkg::PIXEL_WIDTH_DEFAULT,
   parameter int MAX_IN_SIZE  = mp2_pkg::MAX_IN_SIZE_DEFAULT,
   parameter int MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [PIXEL_WIDTH-1:0]         req_pixel_value,
   // pooled output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [PIXEL_WIDTH-1:0]         rsp_pooled_value,
   output logic                                  rsp_last_in_row,
   output logic                                  rsp_last_in_map,
   output logic                                  rsp_last_in_layer,
   // control register writes
   input  logic                                  csr_wr_en,
   input  logic [mp2_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mp2_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int CW         = $clog2(MAX_IN_SIZE);
   localparam int NW         = $clog2(MAX_IN_SIZE + 1);
   localparam int OW         = $clog2(MAX_IN_SIZE / 2 + 1);
   localparam int LINE_DEPTH = MAX_IN_SIZE / 2;
   localparam int LW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int KW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int HW         = $clog2(MAX_CHANNELS + 1);

   logic [mp2_pkg::IN_SIZE_WIDTH-1:0]       in_size_ff;
   logic [mp2_pkg::POOLED_DIM_WIDTH-1:0]    pooled_dim_ff;
   logic [mp2_pkg::CHANNEL_COUNT_WIDTH-1:0] channel_count_ff;

   logic [NW-1:0] eff_in;
   logic [OW-1:0] half_in;
   logic [OW-1:0] eff_out;
   logic [OW-1:0] out_last;
   logic [OW:0]   span;
   logic [HW-1:0] eff_ch;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [KW-1:0] chan_ff, chan_in;

   logic in_square;
   logic col_wrap, row_wrap, chan_wrap;
   logic accept;
   logic s1_advance;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   mp2_pkg::pool_ctrl_type ctrl;
   mp2_pkg::flags_type     out_flags;
   logic [LW-1:0]          slot;

   // Control register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         in_size_ff       <= mp2_pkg::IN_SIZE_RESET;
         pooled_dim_ff    <= mp2_pkg::POOLED_DIM_RESET;
         channel_count_ff <= mp2_pkg::CHANNEL_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mp2_pkg::CSR_IN_SIZE: begin
               in_size_ff <= csr_wdata[mp2_pkg::IN_SIZE_WIDTH-1:0];
            end
            mp2_pkg::CSR_POOLED_DIM: begin
               pooled_dim_ff <= csr_wdata[mp2_pkg::POOLED_DIM_WIDTH-1:0];
            end
            mp2_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_ff <= csr_wdata[mp2_pkg::CHANNEL_COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the register values into their legal ranges
   always_comb begin
      if (in_size_ff < 9'd2) begin
         eff_in = NW'(2);
      end else if (32'(in_size_ff) > 32'(MAX_IN_SIZE)) begin
         eff_in = NW'(MAX_IN_SIZE);
      end else begin
         eff_in = NW'(in_size_ff);
      end
   end

   assign half_in = OW'(eff_in >> 1);

   always_comb begin
      if (pooled_dim_ff == '0) begin
         eff_out = OW'(1);
      end else if (32'(pooled_dim_ff) > 32'(half_in)) begin
         eff_out = half_in;
      end else begin
         eff_out = OW'(pooled_dim_ff);
      end
   end

   always_comb begin
      if (channel_count_ff == '0) begin
         eff_ch = HW'(1);
      end else if (32'(channel_count_ff) > 32'(MAX_CHANNELS)) begin
         eff_ch = HW'(MAX_CHANNELS);
      end else begin
         eff_ch = HW'(channel_count_ff);
      end
   end

   assign out_last = eff_out - OW'(1);
   assign span     = {eff_out, 1'b0};

   // Position decode for the current pixel
   assign in_square = (32'(row_ff) < 32'(span)) && (32'(col_ff) < 32'(span));
   assign col_wrap  = (32'(col_ff) + 32'd1) >= 32'(eff_in);
   assign row_wrap  = (32'(row_ff) + 32'd1) >= 32'(eff_in);
   assign chan_wrap = (32'(chan_ff) + 32'd1) >= 32'(eff_ch);

   always_comb begin
      ctrl.keep_left  = in_square && !col_ff[0];
      ctrl.store_pair = in_square && col_ff[0] && !row_ff[0];
      ctrl.emit       = in_square && col_ff[0] && row_ff[0];
      ctrl.flags.last_in_row   = 32'(col_ff >> 1) == 32'(out_last);
      ctrl.flags.last_in_map   = ctrl.flags.last_in_row
                                 && (32'(row_ff >> 1) == 32'(out_last));
      ctrl.flags.last_in_layer = ctrl.flags.last_in_map && chan_wrap;
   end

   assign slot = LW'(col_ff >> 1);

   // Column, row and channel counters
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      chan_in = chan_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            if (row_wrap) begin
               row_in  = '0;
               chan_in = chan_wrap ? '0 : chan_ff + KW'(1);
            end else begin
               row_in = row_ff + CW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         chan_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         chan_ff <= chan_in;
      end
   end

   // Two-stage flow control: stage 1 (line store read) and output register
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept && ctrl.emit) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   mp2_window_path #(
      .PIXEL_WIDTH (PIXEL_WIDTH),
      .LINE_DEPTH  (LINE_DEPTH),
      .LW          (LW)
   ) u_window_path (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .ctrl         (ctrl),
      .slot         (slot),
      .pixel        (req_pixel_value),
      .s1_advance   (s1_advance),
      .pooled_value (rsp_pooled_value),
      .flags        (out_flags)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_last_in_row   = out_flags.last_in_row;
   assign rsp_last_in_map   = out_flags.last_in_map;
   assign rsp_last_in_layer = out_flags.last_in_layer;

   // Markers nest: end of layer implies end of map implies end of row
   a_flags_nest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_last_in_layer || rsp_last_in_map)
                     && (!rsp_last_in_map || rsp_last_in_row)))
      else $error("pooling end markers do not nest");

   // A completed window always lands in stage 1
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (accept && ctrl.emit) |=> s1_valid_ff)
      else $error("completed window lost before stage 1");

   // A stage 1 transfer always presents a result next cycle
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid)
      else $error("stage 1 transfer did not reach the output");

endmodule
